// File: rtl/core/rti_pkg.sv
package rti_pkg;

    // field widths
    localparam int COORD_W = 16;
    localparam int EDGE_W  = 17;
    localparam int CROSS_W = 35;
    localparam int PROD_W  = 52;
    localparam int DOT_W   = 54;
    localparam int DEN_W   = 53;
    localparam int MDET_W  = 40;
    localparam int UV_W    = 17;
    localparam int DIST_W  = 32;

    // divider steps: distance needs 32 quotient bits, u and v need 17
    localparam int T_STEPS  = 32;
    localparam int UV_STEPS = 17;

    // register map, byte address 8 * index
    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_MIN_DET  = 3'd6
    } reg_idx_t;

    localparam logic [COORD_W-1:0] DIR_Z_RESET   = 16'd256;
    localparam logic [MDET_W-1:0]  MIN_DET_RESET = 40'd1678;

    // one step of a restoring divider
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic             qbit;
    } div_step_t;

    // one pipeline stage of the three dividers
    typedef struct packed {
        logic                hit;
        logic                tneg;
        logic                sat;
        logic [DEN_W-1:0]    den;
        logic [DEN_W-1:0]    ur;
        logic [DEN_W-1:0]    vr;
        logic [DEN_W-1:0]    tr;
        logic [UV_W-1:0]     ub;
        logic [UV_W-1:0]     vb;
        logic [T_STEPS-1:0]  tb;
        logic [UV_W-1:0]     uq;
        logic [UV_W-1:0]     vq;
        logic [T_STEPS-1:0]  tq;
    } div_stage_t;

    // shift in one numerator bit, subtract the divisor if it fits
    function automatic div_step_t div_step(input logic [DEN_W-1:0] rem,
                                           input logic nbit,
                                           input logic [DEN_W-1:0] den);
        logic [DEN_W:0] r2;
        div_step_t      res;
        r2 = {rem, nbit};
        if (r2 >= {1'b0, den})
        begin
            r2       = r2 - {1'b0, den};
            res.qbit = 1'b1;
        end
        else
        begin
            res.qbit = 1'b0;
        end
        res.rem = r2[DEN_W-1:0];
        return res;
    endfunction

endpackage

// File: rtl/core/ray_triangle_intersect_unit.sv
// channel  | ports                                      | handshake
// ---------+--------------------------------------------+---------------------------
// triangle | a_x..c_z                                   | start & !busy, busy is 0
// result   | hit, bary_u, bary_v, distance              | done, one cycle, no stall
// config   | psel penable pwrite paddr pwdata prdata    | APB, pready always high
//
// one triangle word per cycle; results leave in the order that the triangles entered
// seven stages form edges, cross and dot products, then 32 divider stages
// (one quotient bit each) produce distance, u and v, plus one output stage
// rst_n clears valid bits and registers; datapath registers are not reset
// the result side cannot stall, so nothing ever holds the pipeline
module ray_triangle_intersect_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  a_x,
    input  logic signed [15:0]  a_y,
    input  logic signed [15:0]  a_z,
    input  logic signed [15:0]  b_x,
    input  logic signed [15:0]  b_y,
    input  logic signed [15:0]  b_z,
    input  logic signed [15:0]  c_x,
    input  logic signed [15:0]  c_y,
    input  logic signed [15:0]  c_z,
    output logic                done,
    output logic                hit,
    output logic [16:0]         bary_u,
    output logic [16:0]         bary_v,
    output logic signed [31:0]  distance,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int CW = rti_pkg::COORD_W;
    localparam int EW = rti_pkg::EDGE_W;
    localparam int XW = rti_pkg::CROSS_W;
    localparam int PW = rti_pkg::PROD_W;
    localparam int DW = rti_pkg::DOT_W;
    localparam int NW = rti_pkg::DEN_W;
    localparam int NS = rti_pkg::T_STEPS;

    // configuration registers
    logic signed [CW-1:0]            org_reg [3];
    logic signed [CW-1:0]            dir_reg [3];
    logic [rti_pkg::MDET_W-1:0]      min_det_reg;
    rti_pkg::reg_idx_t               widx;
    logic                            wr_en;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign widx   = rti_pkg::reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0]  <= '0;
            org_reg[1]  <= '0;
            org_reg[2]  <= '0;
            dir_reg[0]  <= '0;
            dir_reg[1]  <= '0;
            dir_reg[2]  <= rti_pkg::DIR_Z_RESET;
            min_det_reg <= rti_pkg::MIN_DET_RESET;
        end
        else if (wr_en)
        begin
            unique case (widx)
                rti_pkg::REG_ORIGIN_X: org_reg[0]  <= pwdata[CW-1:0];
                rti_pkg::REG_ORIGIN_Y: org_reg[1]  <= pwdata[CW-1:0];
                rti_pkg::REG_ORIGIN_Z: org_reg[2]  <= pwdata[CW-1:0];
                rti_pkg::REG_DIR_X:    dir_reg[0]  <= pwdata[CW-1:0];
                rti_pkg::REG_DIR_Y:    dir_reg[1]  <= pwdata[CW-1:0];
                rti_pkg::REG_DIR_Z:    dir_reg[2]  <= pwdata[CW-1:0];
                rti_pkg::REG_MIN_DET:  min_det_reg <= pwdata[rti_pkg::MDET_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        prdata = '0;
        unique case (widx)
            rti_pkg::REG_ORIGIN_X: prdata = {48'd0, org_reg[0]};
            rti_pkg::REG_ORIGIN_Y: prdata = {48'd0, org_reg[1]};
            rti_pkg::REG_ORIGIN_Z: prdata = {48'd0, org_reg[2]};
            rti_pkg::REG_DIR_X:    prdata = {48'd0, dir_reg[0]};
            rti_pkg::REG_DIR_Y:    prdata = {48'd0, dir_reg[1]};
            rti_pkg::REG_DIR_Z:    prdata = {48'd0, dir_reg[2]};
            rti_pkg::REG_MIN_DET:  prdata = {24'd0, min_det_reg};
            default:               prdata = '0;
        endcase
    end

    // stage 1: edges and origin offset
    logic signed [CW-1:0] av [3];
    logic signed [CW-1:0] bv [3];
    logic signed [CW-1:0] cv [3];
    logic                 v1_reg;
    logic signed [EW-1:0] e1_1_reg [3];
    logic signed [EW-1:0] e2_1_reg [3];
    logic signed [EW-1:0] s_1_reg  [3];

    assign av[0] = a_x;
    assign av[1] = a_y;
    assign av[2] = a_z;
    assign bv[0] = b_x;
    assign bv[1] = b_y;
    assign bv[2] = b_z;
    assign cv[0] = c_x;
    assign cv[1] = c_y;
    assign cv[2] = c_z;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_1_reg[i] <= EW'(bv[i]) - EW'(av[i]);
            e2_1_reg[i] <= EW'(cv[i]) - EW'(av[i]);
            s_1_reg[i]  <= EW'(org_reg[i]) - EW'(av[i]);
        end
    end

    // stage 2: cross product terms
    logic                  v2_reg;
    logic signed [33:0]    pm_2_reg [6];
    logic signed [33:0]    qm_2_reg [6];
    logic signed [EW-1:0]  e1_2_reg [3];
    logic signed [EW-1:0]  e2_2_reg [3];
    logic signed [EW-1:0]  s_2_reg  [3];

    always_ff @(posedge clk)
    begin
        pm_2_reg[0] <= 34'(dir_reg[1] * 34'(e2_1_reg[2]));
        pm_2_reg[1] <= 34'(dir_reg[2] * 34'(e2_1_reg[1]));
        pm_2_reg[2] <= 34'(dir_reg[2] * 34'(e2_1_reg[0]));
        pm_2_reg[3] <= 34'(dir_reg[0] * 34'(e2_1_reg[2]));
        pm_2_reg[4] <= 34'(dir_reg[0] * 34'(e2_1_reg[1]));
        pm_2_reg[5] <= 34'(dir_reg[1] * 34'(e2_1_reg[0]));
        qm_2_reg[0] <= 34'(s_1_reg[1] * 34'(e1_1_reg[2]));
        qm_2_reg[1] <= 34'(s_1_reg[2] * 34'(e1_1_reg[1]));
        qm_2_reg[2] <= 34'(s_1_reg[2] * 34'(e1_1_reg[0]));
        qm_2_reg[3] <= 34'(s_1_reg[0] * 34'(e1_1_reg[2]));
        qm_2_reg[4] <= 34'(s_1_reg[0] * 34'(e1_1_reg[1]));
        qm_2_reg[5] <= 34'(s_1_reg[1] * 34'(e1_1_reg[0]));
        e1_2_reg    <= e1_1_reg;
        e2_2_reg    <= e2_1_reg;
        s_2_reg     <= s_1_reg;
    end

    // stage 3: cross products p and q
    logic                  v3_reg;
    logic signed [XW-1:0]  p_3_reg  [3];
    logic signed [XW-1:0]  q_3_reg  [3];
    logic signed [EW-1:0]  e1_3_reg [3];
    logic signed [EW-1:0]  e2_3_reg [3];
    logic signed [EW-1:0]  s_3_reg  [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_3_reg[i] <= XW'(pm_2_reg[2*i]) - XW'(pm_2_reg[2*i+1]);
            q_3_reg[i] <= XW'(qm_2_reg[2*i]) - XW'(qm_2_reg[2*i+1]);
        end
        e1_3_reg <= e1_2_reg;
        e2_3_reg <= e2_2_reg;
        s_3_reg  <= s_2_reg;
    end

    // stage 4: dot product terms
    logic                  v4_reg;
    logic signed [PW-1:0]  dm_4_reg [3];
    logic signed [PW-1:0]  um_4_reg [3];
    logic signed [PW-1:0]  vm_4_reg [3];
    logic signed [PW-1:0]  tm_4_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dm_4_reg[i] <= PW'(e1_3_reg[i] * PW'(p_3_reg[i]));
            um_4_reg[i] <= PW'(s_3_reg[i] * PW'(p_3_reg[i]));
            vm_4_reg[i] <= PW'(dir_reg[i] * PW'(q_3_reg[i]));
            tm_4_reg[i] <= PW'(e2_3_reg[i] * PW'(q_3_reg[i]));
        end
    end

    // stage 5: dot product sums
    logic                  v5_reg;
    logic signed [DW-1:0]  det_5_reg;
    logic signed [DW-1:0]  u_5_reg;
    logic signed [DW-1:0]  v_5_reg;
    logic signed [DW-1:0]  t_5_reg;

    always_ff @(posedge clk)
    begin
        det_5_reg <= DW'(dm_4_reg[0]) + DW'(dm_4_reg[1]) + DW'(dm_4_reg[2]);
        u_5_reg   <= DW'(um_4_reg[0]) + DW'(um_4_reg[1]) + DW'(um_4_reg[2]);
        v_5_reg   <= DW'(vm_4_reg[0]) + DW'(vm_4_reg[1]) + DW'(vm_4_reg[2]);
        t_5_reg   <= DW'(tm_4_reg[0]) + DW'(tm_4_reg[1]) + DW'(tm_4_reg[2]);
    end

    // stage 6: fold determinant sign into s, and so into u, v and t
    logic                  v6_reg;
    logic                  neg5;
    logic signed [DW-1:0]  det_6_reg;
    logic signed [DW-1:0]  u_6_reg;
    logic signed [DW-1:0]  v_6_reg;
    logic signed [DW-1:0]  t_6_reg;

    assign neg5 = (det_5_reg <= 0);

    always_ff @(posedge clk)
    begin
        det_6_reg <= neg5 ? -det_5_reg : det_5_reg;
        u_6_reg   <= neg5 ? -u_5_reg   : u_5_reg;
        v_6_reg   <= neg5 ? -v_5_reg   : v_5_reg;
        t_6_reg   <= neg5 ? -t_5_reg   : t_5_reg;
    end

    // stage 7: hit tests, saturation test and divider setup
    logic                  hit6;
    logic                  tneg6;
    logic [DW-1:0]         tmag6;
    logic [DW:0]           uv_sum6;
    logic [DW+15:0]        den_sh6;
    rti_pkg::div_stage_t   st_init;

    always_comb
    begin
        tneg6   = t_6_reg[DW-1];
        tmag6   = tneg6 ? DW'(-t_6_reg) : DW'(t_6_reg);
        uv_sum6 = (DW+1)'(u_6_reg) + (DW+1)'(v_6_reg);
        den_sh6 = {(DW+16)'(det_6_reg)} << 16;
        hit6    = (det_6_reg != 0)
                && (det_6_reg >= DW'(min_det_reg))
                && (u_6_reg >= 0)
                && (u_6_reg <= det_6_reg)
                && (v_6_reg >= 0)
                && ($signed(uv_sum6) <= (DW+1)'(det_6_reg));

        st_init.hit  = hit6;
        st_init.tneg = tneg6;
        st_init.sat  = ((DW+16)'(tmag6) >= den_sh6);
        st_init.den  = NW'(det_6_reg);
        st_init.ur   = NW'(u_6_reg >>> 1);
        st_init.vr   = NW'(v_6_reg >>> 1);
        st_init.tr   = NW'(tmag6 >> 16);
        st_init.ub   = {u_6_reg[0], 16'd0};
        st_init.vb   = {v_6_reg[0], 16'd0};
        st_init.tb   = {tmag6[15:0], 16'd0};
        st_init.uq   = '0;
        st_init.vq   = '0;
        st_init.tq   = '0;
    end

    // divider stages, one quotient bit each
    logic                 dv_reg [NS+1];
    rti_pkg::div_stage_t  ds_reg [NS+1];

    always_ff @(posedge clk)
    begin
        ds_reg[0] <= st_init;
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_div
        rti_pkg::div_stage_t ds_next;
        rti_pkg::div_step_t  tstep;
        rti_pkg::div_step_t  ustep;
        rti_pkg::div_step_t  vstep;

        always_comb
        begin
            ds_next = ds_reg[k];
            tstep   = rti_pkg::div_step(ds_reg[k].tr, ds_reg[k].tb[NS-1], ds_reg[k].den);
            ustep   = rti_pkg::div_step(ds_reg[k].ur, ds_reg[k].ub[16], ds_reg[k].den);
            vstep   = rti_pkg::div_step(ds_reg[k].vr, ds_reg[k].vb[16], ds_reg[k].den);
            ds_next.tr = tstep.rem;
            ds_next.tb = ds_reg[k].tb << 1;
            ds_next.tq = {ds_reg[k].tq[NS-2:0], tstep.qbit};
            if (k < rti_pkg::UV_STEPS)
            begin
                ds_next.ur = ustep.rem;
                ds_next.ub = ds_reg[k].ub << 1;
                ds_next.uq = {ds_reg[k].uq[15:0], ustep.qbit};
                ds_next.vr = vstep.rem;
                ds_next.vb = ds_reg[k].vb << 1;
                ds_next.vq = {ds_reg[k].vq[15:0], vstep.qbit};
            end
        end

        always_ff @(posedge clk)
        begin
            ds_reg[k+1] <= ds_next;
        end
    end

    // valid bits travel with each word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            for (int i = 0; i <= NS; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= start;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            dv_reg[0] <= v6_reg;
            for (int i = 0; i < NS; i++)
            begin
                dv_reg[i+1] <= dv_reg[i];
            end
        end
    end

    // output stage: distance clamp and zeroing on a miss
    rti_pkg::div_stage_t  fin;
    logic signed [31:0]   dist_next;
    logic                 done_reg;
    logic                 hit_reg;
    logic [16:0]          bary_u_reg;
    logic [16:0]          bary_v_reg;
    logic signed [31:0]   distance_reg;

    assign fin = ds_reg[NS];

    always_comb
    begin
        if (fin.tneg)
        begin
            if (fin.sat || (fin.tq > 32'h8000_0000))
            begin
                dist_next = 32'sh8000_0000;
            end
            else
            begin
                dist_next = -$signed(fin.tq);
            end
        end
        else
        begin
            if (fin.sat || fin.tq[31])
            begin
                dist_next = 32'sh7FFF_FFFF;
            end
            else
            begin
                dist_next = $signed(fin.tq);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= fin.hit;
        bary_u_reg   <= fin.hit ? fin.uq : '0;
        bary_v_reg   <= fin.hit ? fin.vq : '0;
        distance_reg <= fin.hit ? dist_next : '0;
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign bary_u   = bary_u_reg;
    assign bary_v   = bary_v_reg;
    assign distance = distance_reg;

endmodule
